FILE: hw/rtl/tgsm_pkg.sv
// Shared types and constants of the two-gate speed meter.
package tgsm_pkg;

    // Field widths fixed by the interface
    localparam int CMD_W       = 2;
    localparam int EVT_TIME_W  = 32;
    localparam int DIST_W      = 16;
    localparam int SPEED_W     = 32;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;

    // Timer width default
    localparam int TIME_BITS_DEFAULT = 32;

    // distance * 1e6 fits in 36 bits (65535 * 1000000 < 2^36)
    localparam int US_W          = 20;
    localparam int DIVIDEND_W    = DIST_W + US_W;
    localparam logic [US_W-1:0] US_PER_SECOND = US_W'(1000000);

    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

    // Register reset values
    localparam logic [DIST_W-1:0] GATE_DISTANCE_RST = DIST_W'(1000);
    localparam logic [CFG_W-1:0]  SPEED_LIMIT_RST   = CFG_W'(3000);
    localparam logic [CFG_W-1:0]  LOCKOUT_US_RST    = CFG_W'(50000);

    // Event kinds
    typedef enum logic [CMD_W-1:0] {
        CMD_NONE  = 2'd0,
        CMD_ENTRY = 2'd1,
        CMD_EXIT  = 2'd2,
        CMD_BOTH  = 2'd3
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GATE_DISTANCE = 2'd0,
        CFG_SPEED_LIMIT   = 2'd1,
        CFG_LOCKOUT_US    = 2'd2
    } t_cfg_idx;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_EMIT
    } t_state;

endpackage

FILE: hw/rtl/two_gate_speed_meter.sv
// Two-gate speed meter: lockout filter, entry/exit timing and serial speed division.
//
// Input channel: i_in_valid with i_command / i_event_time; a transfer happens on a
// rising edge with i_in_valid high and o_in_stall low. Output channel: o_out_valid with
// o_accepted, o_measured, o_speed_centi, o_over_limit; a transfer happens with
// o_out_valid high and i_out_stall low. Exactly one result per input event.
// Configuration: i_cfg_valid / o_cfg_ready (always ready) with i_cfg_index and
// i_cfg_data; write only while no event is in flight.
// Events that measure nothing pass from the input transfer through the evaluate and
// emit states into the output register. A counted exit event runs the bit-serial
// divider, one quotient bit per cycle over the 36-bit dividend, before it is emitted.
// One event is worked on at a time: the next input transfer can follow once the
// result is loaded into the output register.
// The output register holds a result while i_out_stall is high; the next event is
// still taken, but its result waits in the controller until the register frees.
// Synchronous active-low reset restores the registers to 1000 / 3000 / 50000 and
// clears the last counted and entry times; no clearing pass is needed.
module two_gate_speed_meter
    import tgsm_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // event input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [EVT_TIME_W-1:0] i_event_time,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_accepted,
    output logic                  o_measured,
    output logic [SPEED_W-1:0]    o_speed_centi,
    output logic                  o_over_limit,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

    t_state                r_state, n_state;

    logic [DIST_W-1:0]     r_gate_distance;
    logic [CFG_W-1:0]      r_speed_limit;
    logic [CFG_W-1:0]      r_lockout_us;

    logic [TIME_BITS-1:0]  r_last_time;
    logic [TIME_BITS-1:0]  r_entry_time;

    t_cmd                  r_cmd;
    logic [TIME_BITS-1:0]  r_time;
    logic                  r_acc;
    logic                  r_meas;
    logic [SPEED_W-1:0]    r_speed;

    logic                  r_out_valid;
    logic                  r_out_acc;
    logic                  r_out_meas;
    logic [SPEED_W-1:0]    r_out_speed;
    logic                  r_out_over;

    logic [TIME_BITS-1:0]  since;
    logic                  counted;
    logic                  is_entry;
    logic                  is_exit;
    logic [TIME_BITS-1:0]  interval;
    logic [DIVIDEND_W-1:0] dividend;
    logic                  div_start;
    logic                  div_busy;
    logic                  div_done;
    logic [SPEED_W-1:0]    div_quo;
    logic                  in_xfer;
    logic                  out_free;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Event decode; both flags count as entry
    always_comb begin
        is_entry = 1'b0;
        is_exit  = 1'b0;
        unique case (r_cmd) inside
            CMD_ENTRY, CMD_BOTH: is_entry = 1'b1;
            CMD_EXIT:            is_exit  = 1'b1;
            default:             ;
        endcase
    end

    // Lockout check and speed operands
    always_comb begin
        since    = r_time - r_last_time;
        counted  = (CMP_W'(since) > CMP_W'(r_lockout_us));
        interval = r_time - r_entry_time;
        dividend = DIVIDEND_W'(r_gate_distance) * DIVIDEND_W'(US_PER_SECOND);
    end

    // Next state
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (counted && is_exit) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_DIV: begin
                if (div_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_distance <= GATE_DISTANCE_RST;
            r_speed_limit   <= SPEED_LIMIT_RST;
            r_lockout_us    <= LOCKOUT_US_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GATE_DISTANCE: r_gate_distance <= i_cfg_data[DIST_W-1:0];
                CFG_SPEED_LIMIT:   r_speed_limit   <= i_cfg_data;
                CFG_LOCKOUT_US:    r_lockout_us    <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // Gate timing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time  <= '0;
            r_entry_time <= '0;
        end else if (r_state == S_EVAL && counted) begin
            r_last_time <= r_time;
            if (is_entry) r_entry_time <= r_time;
        end
    end

    // Event capture and per-event result
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd  <= t_cmd'(i_command);
            r_time <= TIME_BITS'(i_event_time);
        end
        if (r_state == S_EVAL) begin
            r_acc   <= counted;
            r_meas  <= counted && is_exit;
            r_speed <= '0;
        end
        if (r_state == S_DIV && div_done) begin
            r_speed <= div_quo;
        end
    end

    tgsm_divider #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (interval),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_out_acc   <= r_acc;
            r_out_meas  <= r_meas;
            r_out_speed <= r_speed;
            r_out_over  <= r_meas && (r_speed > r_speed_limit);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_accepted    = r_out_acc;
    assign o_measured    = r_out_meas;
    assign o_speed_centi = r_out_speed;
    assign o_over_limit  = r_out_over;

    // Divider only runs while the controller waits on it
    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == S_DIV))
        else $error("divider running outside S_DIV");

    // A new result is only loaded from the emit state
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_EMIT))
        else $error("result appeared without emit");

    // A measurement implies the event was counted
    a_meas_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_measured) |-> o_accepted)
        else $error("measurement from a locked-out event");

    // Over-limit only flags measured results
    a_over_meas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_over_limit) |-> o_measured)
        else $error("over-limit without measurement");

endmodule

FILE: hw/rtl/tgsm_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, saturated to 32 bits.
module tgsm_divider
    import tgsm_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [TIME_BITS-1:0]  i_divisor,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [SPEED_W-1:0]    o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_count;
    logic [DIVIDEND_W-1:0] r_quo;     // dividend bits shift out, quotient bits shift in
    logic [TIME_BITS-1:0]  r_rem;
    logic [TIME_BITS-1:0]  r_divisor;

    logic [TIME_BITS:0]    rem_sh;
    logic [TIME_BITS:0]    rem_diff;
    logic                  fits;

    // One restoring step
    always_comb begin
        rem_sh   = {r_rem, r_quo[DIVIDEND_W-1]};
        rem_diff = rem_sh - {1'b0, r_divisor};
        fits     = (rem_sh >= {1'b0, r_divisor});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_count <= r_count - 1'b1;
                if (r_count == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath; a zero divisor yields all ones, which saturates
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo     <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
            r_rem <= fits ? rem_diff[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = (|r_quo[DIVIDEND_W-1:SPEED_W]) ? SPEED_MAX : r_quo[SPEED_W-1:0];

    // A finish is only signaled after a run
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a run");

    // A start never lands on a run in progress
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

endmodule

FILE: tb/tgsm_checker.sv
// Result checker for the two-gate speed meter: tracks registers, predicts readings, compares.
module tgsm_checker
    import tgsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // event channel
    input  logic                  i_evt_valid,
    input  logic                  i_evt_stall,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [EVT_TIME_W-1:0] i_event_time,
    // result channel
    input  logic                  i_res_valid,
    input  logic                  i_res_stall,
    input  logic                  i_accepted,
    input  logic                  i_measured,
    input  logic [SPEED_W-1:0]    i_speed_centi,
    input  logic                  i_over_limit,
    // register writes
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // status toward the testbench top
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_counted,
    output int                    o_measured,
    output int                    o_over,
    output int                    o_saturated
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               accepted;
        logic               measured;
        logic [SPEED_W-1:0] speed;
        logic               over;
    } t_gate_reading;

    // register copies
    logic [DIST_W-1:0]     distance_cfg;
    logic [CFG_W-1:0]      limit_cfg;
    logic [CFG_W-1:0]      lockout_cfg;

    // timing state
    logic [EVT_TIME_W-1:0] last_counted;
    logic [EVT_TIME_W-1:0] entry_stamp;

    t_gate_reading         pending_readings[$];

    // distance * 1e6 / interval, zero interval and overflow saturate
    function automatic logic [SPEED_W-1:0] speed_for(logic [EVT_TIME_W-1:0] interval);
        logic [63:0] quotient;
        if (interval == '0)
            return SPEED_MAX;
        quotient = (64'(distance_cfg) * 64'(US_PER_SECOND)) / 64'(interval);
        if (quotient > 64'(SPEED_MAX))
            return SPEED_MAX;
        return quotient[SPEED_W-1:0];
    endfunction

    // lockout filter and entry/exit handling for one event
    function automatic t_gate_reading gate_event_reading(t_cmd cmd,
                                                         logic [EVT_TIME_W-1:0] stamp);
        t_gate_reading         r;
        logic [EVT_TIME_W-1:0] since;
        r = '0;
        since = stamp - last_counted;
        if (since > lockout_cfg) begin
            r.accepted = 1'b1;
            // entry bit wins when both sensors fire
            if (cmd[0]) begin
                entry_stamp = stamp;
            end else if (cmd[1]) begin
                r.measured = 1'b1;
                r.speed    = speed_for(stamp - entry_stamp);
                r.over     = (r.speed > limit_cfg);
            end
            last_counted = stamp;
        end
        return r;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_gate_reading want;
        if (!i_rst_n) begin
            distance_cfg = GATE_DISTANCE_RST;
            limit_cfg    = SPEED_LIMIT_RST;
            lockout_cfg  = LOCKOUT_US_RST;
            last_counted = '0;
            entry_stamp  = '0;
            pending_readings.delete();
        end else begin
            // register write transfer
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_GATE_DISTANCE: distance_cfg = i_cfg_data[DIST_W-1:0];
                    CFG_SPEED_LIMIT:   limit_cfg    = i_cfg_data;
                    CFG_LOCKOUT_US:    lockout_cfg  = i_cfg_data;
                    default: ;
                endcase
            end
            // result transfer: compare against the oldest reading
            if (i_res_valid && !i_res_stall) begin
                if (pending_readings.size() == 0) begin
                    $error("result transfer with no event outstanding");
                    o_errors++;
                end else begin
                    want = pending_readings.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(i_accepted));
                    check_field("measured", 32'(want.measured), 32'(i_measured));
                    check_field("speed_centi", want.speed, i_speed_centi);
                    check_field("over_limit", 32'(want.over), 32'(i_over_limit));
                    o_counted  += int'(want.accepted);
                    o_measured += int'(want.measured);
                    o_over     += int'(want.over);
                    if (want.measured && want.speed == SPEED_MAX)
                        o_saturated++;
                end
            end
            // event transfer
            if (i_evt_valid && !i_evt_stall)
                pending_readings.push_back(gate_event_reading(t_cmd'(i_command), i_event_time));
        end
        o_pending = pending_readings.size();
    end

endmodule

FILE: tb/two_gate_speed_meter_tb.sv
// Testbench top for the two-gate speed meter: clock, reset, stimulus and verdict.
module two_gate_speed_meter_tb
    import tgsm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 3000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 265;
    localparam int SHORT_ITEMS = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [CMD_W-1:0]      i_command;
    logic [EVT_TIME_W-1:0] i_event_time;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_accepted;
    logic                  o_measured;
    logic [SPEED_W-1:0]    o_speed_centi;
    logic                  o_over_limit;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;

    int mismatches, outstanding, n_counted, n_measured, n_over, n_saturated;

    // stimulus state
    logic [EVT_TIME_W-1:0] clock_us;
    logic [CFG_W-1:0]      lockout_now;
    int unsigned           span_now;
    bit                    tx_bursts;
    bit                    rx_bursts;
    int                    sent;
    int                    settings;

    two_gate_speed_meter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_event_time  (i_event_time),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_accepted    (o_accepted),
        .o_measured    (o_measured),
        .o_speed_centi (o_speed_centi),
        .o_over_limit  (o_over_limit),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    tgsm_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_evt_valid   (i_in_valid),
        .i_evt_stall   (o_in_stall),
        .i_command     (i_command),
        .i_event_time  (i_event_time),
        .i_res_valid   (o_out_valid),
        .i_res_stall   (i_out_stall),
        .i_accepted    (o_accepted),
        .i_measured    (o_measured),
        .i_speed_centi (o_speed_centi),
        .i_over_limit  (o_over_limit),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (mismatches),
        .o_pending     (outstanding),
        .o_counted     (n_counted),
        .o_measured    (n_measured),
        .o_over        (n_over),
        .o_saturated   (n_saturated)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // result-side back-pressure in short bursts
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_bursts && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog: too long without any transfer ends the run
    always @(posedge i_clk) begin
        int quiet;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one event transfer, with an optional sender gap first
    task automatic post_event(t_cmd cmd, logic [EVT_TIME_W-1:0] stamp);
        if (tx_bursts && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_event_time <= stamp;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
    endtask

    task automatic step_event(t_cmd cmd, logic [EVT_TIME_W-1:0] delta);
        clock_us += delta;
        post_event(cmd, clock_us);
    endtask

    // stop sending and wait for every reading to come back
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // write all three registers; the block must be idle
    task automatic configure(logic [DIST_W-1:0] spacing, logic [CFG_W-1:0] limit,
                             logic [CFG_W-1:0] lock);
        write_reg(CFG_GATE_DISTANCE, {16'($urandom()), spacing});
        write_reg(CFG_SPEED_LIMIT, limit);
        write_reg(CFG_LOCKOUT_US, lock);
        i_cfg_valid <= 1'b0;
        lockout_now = lock;
        settings++;
    endtask

    // gap long enough to pass the lockout
    function automatic logic [EVT_TIME_W-1:0] open_gap();
        logic [63:0] d;
        d = 64'(lockout_now) + 64'd1 + 64'($urandom_range(0, span_now));
        return 32'(d);
    endfunction

    // gap that stays inside the lockout window
    function automatic logic [EVT_TIME_W-1:0] closed_gap();
        return $urandom_range(0, lockout_now);
    endfunction

    // pick register values for one random phase
    task automatic phase_settings(int phase);
        logic [DIST_W-1:0] spacing;
        logic [CFG_W-1:0]  lock;
        logic [CFG_W-1:0]  limit;
        logic [63:0]       nominal;
        int unsigned       span;
        spacing = 16'($urandom_range(1, 65535));
        case (phase)
            0: begin
                lock = $urandom_range(1000, 100000);
                span = lock;
            end
            1: begin
                spacing = 16'hFFFF;
                lock = $urandom_range(0, 15);
                span = 40;
            end
            2: begin
                spacing = 16'd1;
                lock = $urandom_range(32'h8000_0000, 32'hF000_0000);
                span = 32'h0FFF_FFFF;
            end
            3: begin
                lock = 32'hFFFF_FFFF;
                span = 0;
            end
            default: begin
                case ($urandom_range(0, 2))
                    0: begin
                        lock = $urandom_range(0, 15);
                        span = $urandom_range(8, 200);
                    end
                    1: begin
                        lock = $urandom_range(1000, 100000);
                        span = $urandom_range(100, 200000);
                    end
                    default: begin
                        lock = $urandom();
                        span = $urandom();
                    end
                endcase
            end
        endcase
        // keep a passing gap below one timer wrap
        if (lock >= 32'hFFFF_FFFE)
            span = 0;
        else if (64'(span) > 64'(32'hFFFF_FFFF - lock - 32'd1))
            span = 32'hFFFF_FFFF - lock - 32'd1;
        span_now = span;
        // limit near the typical speed of this phase, or an extreme
        nominal = (64'(spacing) * 64'd1000000) / (64'(lock) + 64'd1 + 64'(span / 2));
        if (nominal > 64'(SPEED_MAX))
            nominal = 64'(SPEED_MAX);
        case ($urandom_range(0, 3))
            0: limit = '0;
            1: limit = SPEED_MAX;
            default: begin
                nominal = nominal * 64'($urandom_range(50, 150)) / 64'd100;
                limit = (nominal > 64'(SPEED_MAX)) ? SPEED_MAX : 32'(nominal);
            end
        endcase
        if (phase == 1)
            limit = SPEED_MAX;
        if (phase == 2)
            limit = '0;
        settle();
        configure(spacing, limit, lock);
    endtask

    // mostly entry/exit pairs with random spacing, some noise events
    task automatic random_sequence(output int posted);
        t_cmd noise_cmd;
        posted = 0;
        if ($urandom_range(0, 9) < 7 && lockout_now != 32'hFFFF_FFFF) begin
            step_event(($urandom_range(0, 3) == 0) ? CMD_BOTH : CMD_ENTRY, open_gap());
            posted++;
            if ($urandom_range(0, 3) == 0) begin
                step_event(t_cmd'($urandom_range(0, 3)), closed_gap());
                posted++;
            end
            if ($urandom_range(0, 5) == 0) begin
                step_event(CMD_NONE, open_gap());
                posted++;
            end
            step_event(CMD_EXIT, open_gap());
            posted++;
        end else begin
            noise_cmd = t_cmd'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0:       step_event(noise_cmd, $urandom());
                1:       step_event(noise_cmd, closed_gap());
                2:       step_event(noise_cmd, lockout_now);
                default: step_event(noise_cmd, lockout_now + 32'd1);
            endcase
            posted++;
        end
    endtask

    initial begin
        int  quota;
        int  done_in_phase;
        int  posted;
        bit  paused;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_command    <= CMD_NONE;
        i_event_time <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= CFG_GATE_DISTANCE;
        i_cfg_data   <= '0;
        clock_us     = '0;
        lockout_now  = LOCKOUT_US_RST;
        span_now     = 0;
        tx_bursts    = 1'b1;
        rx_bursts    = 1'b1;
        paused       = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset registers, lockout boundary, exit before any entry
        post_event(CMD_EXIT, '0);
        step_event(CMD_EXIT, 32'd50000);
        step_event(CMD_EXIT, 32'd1);
        step_event(CMD_ENTRY, 32'd50001);
        step_event(CMD_NONE, 32'd50001);
        step_event(CMD_EXIT, 32'd50001);
        // both sensors act as entry; a slow pass stays under the limit
        step_event(CMD_BOTH, 32'd60000);
        step_event(CMD_EXIT, 32'd400000);
        // a locked-out entry must not move the stored entry time
        step_event(CMD_ENTRY, 32'd100000);
        step_event(CMD_ENTRY, 32'd10);
        step_event(CMD_EXIT, 32'd60000);
        // timer wrap between entry and exit, then the all-ones stamp
        clock_us = 32'hFFFF_0000;
        post_event(CMD_ENTRY, clock_us);
        step_event(CMD_EXIT, 32'h0002_0000);
        clock_us = 32'hFFFF_FFFF;
        post_event(CMD_EXIT, clock_us);

        // widest gate, no lockout, top limit: zero interval and overflow
        settle();
        configure(16'hFFFF, SPEED_MAX, '0);
        step_event(CMD_ENTRY, 32'd1);
        step_event(CMD_NONE, 32'd1);
        post_event(CMD_EXIT, clock_us - 32'd1);
        step_event(CMD_ENTRY, 32'd2);
        step_event(CMD_EXIT, 32'd5);
        step_event(CMD_ENTRY, 32'd1);
        step_event(CMD_EXIT, 32'd16);
        step_event(CMD_NONE, 32'd0);

        // zero distance, zero limit
        settle();
        configure('0, '0, '0);
        step_event(CMD_ENTRY, 32'd3);
        step_event(CMD_EXIT, 32'd3);

        // random phases, the last one without idling
        for (int p = 0; p < PHASES; p++) begin
            tx_bursts = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            rx_bursts = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            phase_settings(p);
            quota = (lockout_now == 32'hFFFF_FFFF) ? SHORT_ITEMS : PHASE_ITEMS;
            done_in_phase = 0;
            while (done_in_phase < quota) begin
                // drain completely once in the middle of the first phase
                if (!paused && p == 0 && done_in_phase >= quota / 2) begin
                    settle();
                    paused = 1'b1;
                end
                random_sequence(posted);
                done_in_phase += posted;
            end
        end

        settle();
        repeat (40) @(posedge i_clk);
        $display("Covered %0d events over %0d register settings: %0d counted, %0d measured",
                 sent, settings, n_counted, n_measured);
        $display("Speeds: %0d saturated, %0d over the limit", n_saturated, n_over);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
